[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rsa_pkg.sv]
// ---------------------------------------------------------------------------
// rsa_pkg
// Types and codes shared by the register slot allocator and its slot cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsa_pkg;

  // Field widths
  localparam int OP_W    = 3;
  localparam int ACT_W   = 3;
  localparam int VREG_W  = 8;
  localparam int OFF_W   = 12;
  localparam int FRAME_W = 11;
  localparam int RANK_W  = 8;
  localparam int CNT_W   = 9;
  localparam int VREGS   = 256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_BEGIN_FUNC  = 3'd0;
  localparam logic [OP_W-1:0] OP_BEGIN_BLOCK = 3'd1;
  localparam logic [OP_W-1:0] OP_SRC         = 3'd2;
  localparam logic [OP_W-1:0] OP_DEST        = 3'd3;
  localparam logic [OP_W-1:0] OP_SCRATCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_END_BLOCK   = 3'd5;
  localparam logic [OP_W-1:0] OP_FINISH      = 3'd6;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_GRANT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STORE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FLUSHED = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FRAME   = 3'd4;

  // Write controls from the sequencer to one cell
  typedef struct packed {
    logic clr_flags;   // block start: drop occupied and dirty
    logic clr_occ;     // slot evicted or spilled
    logic own;         // take ownership of the request vreg
    logic mark_dirty;  // destination binding
  } cell_ctrl_t;

  // Priority tokens passed down the chain of cells
  typedef struct packed {
    logic hit_found;
    logic free_found;
    logic clean_found;
  } chain_t;

  // One-hot selections made by a cell
  typedef struct packed {
    logic hit;
    logic free;
    logic clean;
  } cell_sel_t;

  // State a cell exposes to the sequencer
  typedef struct packed {
    logic              dirty;
    logic [VREG_W-1:0] owner;
  } cell_stat_t;

endpackage

[hw/rtl/rsa_cell.sv]
// ---------------------------------------------------------------------------
// rsa_cell
// One physical register slot: occupied/dirty flags and owning vreg, plus its
// link in the priority chain that finds the first hit, free and clean slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsa_cell import rsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [VREG_W-1:0] look_vreg,
  input  chain_t            chain_in,
  output chain_t            chain_out,
  output cell_sel_t         sel,
  output cell_stat_t        stat
);

  logic              occ_r;
  logic              dirty_r;
  logic [VREG_W-1:0] owner_r;
  logic              hit_here;

  // Slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      dirty_r <= 1'b0;
      owner_r <= '0;
    end else if (ctrl.clr_flags) begin
      occ_r   <= 1'b0;
      dirty_r <= 1'b0;
    end else begin
      if (ctrl.clr_occ) begin
        occ_r <= 1'b0;
      end
      if (ctrl.own) begin
        occ_r   <= 1'b1;
        owner_r <= look_vreg;
      end
      if (ctrl.mark_dirty) begin
        dirty_r <= 1'b1;
      end
    end
  end

  // Priority chain: the first cell that matches claims the token
  assign hit_here = occ_r && (owner_r == look_vreg);

  assign sel.hit   = hit_here && !chain_in.hit_found;
  assign sel.free  = !occ_r && !chain_in.free_found;
  assign sel.clean = !dirty_r && !chain_in.clean_found;

  assign chain_out.hit_found   = chain_in.hit_found | hit_here;
  assign chain_out.free_found  = chain_in.free_found | !occ_r;
  assign chain_out.clean_found = chain_in.clean_found | !dirty_r;

  assign stat.dirty = dirty_r;
  assign stat.owner = owner_r;

endmodule

[hw/rtl/register_slot_allocator_with_spill.sv]
// ---------------------------------------------------------------------------
// register_slot_allocator_with_spill
// Physical register slot allocator with round-robin spill to the stack frame.
// ---------------------------------------------------------------------------
// One transaction is handled at a time. Begin function, begin block and the
// unused code finish in the accept cycle. A source hit, or a destination or
// scratch request that finds a free or clean slot, passes through accept,
// slot pick and grant; a spill adds a store state and a source miss a fill
// load state. End block scans the slot chain one slot per cycle while no
// dirty slot is found; each dirty slot is spilled before the scan goes on.
// Each spill needs its own state because the frame-offset table is a memory
// with one read and one write port and a registered read, looked up in the
// state before the store. A result waiting in the output register stalls
// only the next emission, not acceptance of the next transaction. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module register_slot_allocator_with_spill import rsa_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [VREG_W-1:0]       in_vreg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ACT_W-1:0]        out_action,
  output logic [$clog2(SLOTS)-1:0] out_slot,
  output logic [VREG_W-1:0]       out_moved_vreg,
  output logic signed [OFF_W-1:0] out_stack_offset,
  output logic [FRAME_W-1:0]      out_frame_size,
  output logic                    out_last
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(SLOTS + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PICK    = 3'd1;
  localparam logic [2:0] S_SPILL   = 3'd2;
  localparam logic [2:0] S_FILL    = 3'd3;
  localparam logic [2:0] S_GRANT   = 3'd4;
  localparam logic [2:0] S_FSCAN   = 3'd5;
  localparam logic [2:0] S_FLUSHED = 3'd6;
  localparam logic [2:0] S_FRAME   = 3'd7;

  // Frame offset of a spill rank: -4*(rank+4)
  function automatic logic [OFF_W-1:0] rank_offset(input logic [RANK_W-1:0] rank);
    logic [RANK_W:0] r4;
    r4 = {1'b0, rank} + (RANK_W+1)'(4);
    return OFF_W'(0) - {1'b0, r4, 2'b00};
  endfunction

  // Frame bytes rounded up to 16: ((8 + 4*count + 15) / 16) * 16
  function automatic logic [FRAME_W-1:0] frame_bytes(input logic [CNT_W-1:0] cnt);
    logic [FRAME_W-1:0] b;
    b = FRAME_W'(8) + {cnt, 2'b00} + FRAME_W'(15);
    return {b[FRAME_W-1:4], 4'b0000};
  endfunction

  // Registers
  logic [2:0]          state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [VREG_W-1:0]   vreg_r, vreg_nxt;
  logic [SLOT_W-1:0]   s_r, s_nxt;
  logic [VREG_W-1:0]   owner_r, owner_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SLOT_W-1:0]   vp_r, vp_nxt;
  logic [CNT_W-1:0]    sc_r, sc_nxt;
  logic [VREGS-1:0]    known_r, known_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]    out_action_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [VREG_W-1:0]   out_vreg_r;
  logic [OFF_W-1:0]    out_off_r;
  logic [FRAME_W-1:0]  out_frame_r;
  logic                out_last_r;
  logic [RANK_W-1:0]   rd_r;

  // Frame offset rank table
  logic [RANK_W-1:0]   rank_mem [VREGS];

  // Cell chain
  chain_t              chain_w [SLOTS+1];
  cell_sel_t           sel_v   [SLOTS];
  cell_stat_t          stat_v  [SLOTS];
  cell_ctrl_t          ctrl_v  [SLOTS];
  logic [SLOTS-1:0]    dirty_v;
  logic [SLOTS-1:0]    hit_v, free_v, clean_v;

  // Decode and datapath
  logic                accept, can_emit;
  logic [SLOT_W-1:0]   hit_idx, free_idx, clean_idx, pick_s, scan_s, sel_idx;
  logic                hit_take, spill_need, scan_done;
  logic                rd_en, wr_en;
  logic [VREG_W-1:0]   rd_addr;
  logic [RANK_W-1:0]   rank_v;
  logic                emit;
  logic [ACT_W-1:0]    e_action;
  logic [SLOT_W-1:0]   e_slot;
  logic [VREG_W-1:0]   e_vreg;
  logic [OFF_W-1:0]    e_off;
  logic [FRAME_W-1:0]  e_frame;
  logic                e_last;
  logic                bind_en, clr_occ_en;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign can_emit = !out_valid_r || out_ready;

  // Chain of slot cells
  assign chain_w[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rsa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl_v[g]),
      .look_vreg (vreg_r),
      .chain_in  (chain_w[g]),
      .chain_out (chain_w[g+1]),
      .sel       (sel_v[g]),
      .stat      (stat_v[g])
    );
    assign dirty_v[g] = stat_v[g].dirty;
    assign hit_v[g]   = sel_v[g].hit;
    assign free_v[g]  = sel_v[g].free;
    assign clean_v[g] = sel_v[g].clean;

    always_comb begin
      ctrl_v[g].clr_flags  = accept && (in_operation == OP_BEGIN_BLOCK);
      ctrl_v[g].clr_occ    = clr_occ_en && (pick_s == SLOT_W'(g));
      ctrl_v[g].own        = bind_en && (s_r == SLOT_W'(g));
      ctrl_v[g].mark_dirty = bind_en && (s_r == SLOT_W'(g)) && (op_r == OP_DEST);
    end
  end

  // One-hot selections to slot indexes
  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    clean_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_v[i])   hit_idx   = hit_idx | SLOT_W'(i);
      if (free_v[i])  free_idx  = free_idx | SLOT_W'(i);
      if (clean_v[i]) clean_idx = clean_idx | SLOT_W'(i);
    end
  end

  // Slot choice: source hit, first free, first clean, else round-robin victim
  assign hit_take   = (op_r == OP_SRC) && chain_w[SLOTS].hit_found;
  assign spill_need = !hit_take && !chain_w[SLOTS].free_found && !chain_w[SLOTS].clean_found;

  always_comb begin
    if (hit_take) begin
      pick_s = hit_idx;
    end else if (chain_w[SLOTS].free_found) begin
      pick_s = free_idx;
    end else if (chain_w[SLOTS].clean_found) begin
      pick_s = clean_idx;
    end else begin
      pick_s = vp_r;
    end
  end

  assign scan_s    = idx_r[SLOT_W-1:0];
  assign scan_done = (idx_r == IDX_W'(SLOTS));
  assign sel_idx   = (state_r == S_FSCAN) ? scan_s : pick_s;

  assign clr_occ_en = (state_r == S_PICK) && !hit_take && !chain_w[SLOTS].free_found;
  assign bind_en    = (state_r == S_GRANT) && can_emit &&
                      ((op_r == OP_SRC) || (op_r == OP_DEST));

  // Rank of the vreg being spilled: recorded one, or the next new one
  assign rank_v = known_r[owner_r] ? rd_r : sc_r[RANK_W-1:0];
  assign wr_en  = (state_r == S_SPILL) && can_emit && !known_r[owner_r];

  // Rank table read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = vreg_r;
    case (state_r)
      S_PICK: begin
        if (spill_need) begin
          rd_en   = 1'b1;
          rd_addr = stat_v[sel_idx].owner;
        end else if (!hit_take && (op_r == OP_SRC)) begin
          rd_en = 1'b1;
        end
      end
      S_SPILL: begin
        rd_en = can_emit && (op_r == OP_SRC);
      end
      S_FSCAN: begin
        if (!scan_done && dirty_v[scan_s]) begin
          rd_en   = 1'b1;
          rd_addr = stat_v[sel_idx].owner;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rank_mem[owner_r] <= sc_r[RANK_W-1:0];
    end
    if (rd_en) begin
      rd_r <= rank_mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    vreg_nxt  = vreg_r;
    s_nxt     = s_r;
    owner_nxt = owner_r;
    idx_nxt   = idx_r;
    vp_nxt    = vp_r;
    sc_nxt    = sc_r;
    known_nxt = known_r;
    emit      = 1'b0;
    e_action  = ACT_GRANT;
    e_slot    = s_r;
    e_vreg    = '0;
    e_off     = '0;
    e_frame   = '0;
    e_last    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_operation;
          vreg_nxt = in_vreg;
          idx_nxt  = '0;
          case (in_operation)
            OP_BEGIN_FUNC: begin
              sc_nxt    = '0;
              vp_nxt    = '0;
              known_nxt = '0;
            end
            OP_SRC, OP_DEST, OP_SCRATCH: state_nxt = S_PICK;
            OP_END_BLOCK:                state_nxt = S_FSCAN;
            OP_FINISH:                   state_nxt = S_FRAME;
            default:                     state_nxt = S_IDLE;
          endcase
        end
      end

      S_PICK: begin
        s_nxt     = pick_s;
        owner_nxt = stat_v[sel_idx].owner;
        if (spill_need) begin
          vp_nxt    = (vp_r == SLOT_W'(SLOTS - 1)) ? '0 : vp_r + SLOT_W'(1);
          state_nxt = S_SPILL;
        end else if (!hit_take && (op_r == OP_SRC)) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_GRANT;
        end
      end

      S_SPILL: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_action = ACT_STORE;
          e_vreg   = owner_r;
          e_off    = rank_offset(rank_v);
          if (!known_r[owner_r]) begin
            known_nxt[owner_r] = 1'b1;
            sc_nxt             = sc_r + CNT_W'(1);
          end
          if (op_r == OP_SRC) begin
            state_nxt = S_FILL;
          end else if (op_r == OP_END_BLOCK) begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_FSCAN;
          end else begin
            state_nxt = S_GRANT;
          end
        end
      end

      S_FILL: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_action  = ACT_LOAD;
          e_vreg    = vreg_r;
          e_off     = known_r[vreg_r] ? rank_offset(rd_r) : '0;
          state_nxt = S_GRANT;
        end
      end

      S_GRANT: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_action  = ACT_GRANT;
          e_vreg    = (op_r == OP_SCRATCH) ? '0 : vreg_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_FSCAN: begin
        if (scan_done) begin
          state_nxt = S_FLUSHED;
        end else if (dirty_v[scan_s]) begin
          s_nxt     = scan_s;
          owner_nxt = stat_v[sel_idx].owner;
          state_nxt = S_SPILL;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_FLUSHED: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_action  = ACT_FLUSHED;
          e_slot    = '0;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_FRAME: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_action  = ACT_FRAME;
          e_slot    = '0;
          e_frame   = frame_bytes(sc_r);
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      vp_r        <= '0;
      sc_r        <= '0;
      known_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      vp_r        <= vp_nxt;
      sc_r        <= sc_nxt;
      known_r     <= known_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    vreg_r  <= vreg_nxt;
    s_r     <= s_nxt;
    owner_r <= owner_nxt;
    if (emit) begin
      out_action_r <= e_action;
      out_slot_r   <= e_slot;
      out_vreg_r   <= e_vreg;
      out_off_r    <= e_off;
      out_frame_r  <= e_frame;
      out_last_r   <= e_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_slot         = out_slot_r;
  assign out_moved_vreg   = out_vreg_r;
  assign out_stack_offset = out_off_r;
  assign out_frame_size   = out_frame_r;
  assign out_last         = out_last_r;

  // Checks
  `ASSERT_ALWAYS(a_chain_onehot, $onehot0(hit_v) && $onehot0(free_v) && $onehot0(clean_v), "chain selected more than one slot")
  `ASSERT_ALWAYS(a_spill_count_range, sc_r <= CNT_W'(VREGS), "spill count beyond register count")
  `ASSERT_NEXT(a_dest_marks_dirty, (state_r == S_GRANT) && can_emit && (op_r == OP_DEST), dirty_v[s_r], "destination slot not dirty after grant")
  `ASSERT_IMPLY(a_closing_last, out_valid_r && ((out_action_r == ACT_GRANT) || (out_action_r == ACT_FLUSHED) || (out_action_r == ACT_FRAME)), out_last_r, "closing transaction without last")

endmodule
